/* hw/rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } mexp_state_t;

endpackage

/* hw/rtl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// mexp_mulmod
// Interleaved shift-add modular multiplier, one bit of op_a per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] op_a,
    input  logic [OPERAND_BITS-1:0] op_b,     // must not exceed modulus
    input  logic [OPERAND_BITS-1:0] modulus,  // nonzero
    output logic                    done,
    output logic [OPERAND_BITS-1:0] product
);

    localparam int CNT_W = $clog2(OPERAND_BITS + 1);
    localparam int SUM_W = OPERAND_BITS + 2;
    localparam int DIF_W = OPERAND_BITS + 3;

    logic [OPERAND_BITS-1:0] a_reg, a_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;
    logic [OPERAND_BITS-1:0] m_reg, m_next;
    logic [OPERAND_BITS-1:0] r_reg, r_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [SUM_W-1:0]        sum;
    logic [DIF_W-1:0]        dif1;
    logic [DIF_W-1:0]        dif2;
    logic [OPERAND_BITS-1:0] r_step;

    // r < m and b <= m keep 2r + b below 3m, so at most two subtractions
    always_comb begin
        sum  = {1'b0, r_reg, 1'b0}
             + (a_reg[OPERAND_BITS-1] ? SUM_W'(b_reg) : SUM_W'(0));
        dif1 = {1'b0, sum} - DIF_W'(m_reg);
        dif2 = {1'b0, sum} - DIF_W'({m_reg, 1'b0});
        if (!dif2[DIF_W-1]) begin
            r_step = dif2[OPERAND_BITS-1:0];
        end else if (!dif1[DIF_W-1]) begin
            r_step = dif1[OPERAND_BITS-1:0];
        end else begin
            r_step = sum[OPERAND_BITS-1:0];
        end
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            r_next    = '0;
            cnt_next  = CNT_W'(OPERAND_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            a_next   = {a_reg[OPERAND_BITS-2:0], 1'b0};
            r_next   = r_step;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

/* hw/rtl/modular_exponentiation_unit.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// message ^ exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  s_*       in         message (OPERAND_BITS bits, unsigned)
//  m_*       out        result  (OPERAND_BITS bits, unsigned)
//  cfg_*     in         register write: 0 exponent, 1 modulus
//
//  one message at a time; the shift-add multiplier does one initial reduction,
//  then a multiply per set exponent bit and a square per exponent bit below
//  the top one; a zero exponent or modulus skips the multiplier
//  synchronous active-low reset; no clearing pass
//  s_tready is high only while idle; a result waits in the output register
//  and the next message is taken while it is held
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((OPERAND_BITS+7)/8)*8-1:0] s_tdata,   // [OPERAND_BITS-1:0] message

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((OPERAND_BITS+7)/8)*8-1:0] m_tdata,   // [OPERAND_BITS-1:0] result

    input  logic                              cfg_wr_en,
    input  logic [mexp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [OPERAND_BITS-1:0]           cfg_wdata
);

    localparam int TDATA_W = ((OPERAND_BITS + 7) / 8) * 8;
    localparam logic [OPERAND_BITS-1:0] ONE = OPERAND_BITS'(1);

    mexp_pkg::mexp_state_t state_reg, state_next;

    logic [OPERAND_BITS-1:0] exponent_reg;
    logic [OPERAND_BITS-1:0] modulus_reg;
    logic [OPERAND_BITS-1:0] exp_reg, exp_next;
    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] sq_reg, sq_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OPERAND_BITS-1:0] m_data_reg, m_data_next;

    logic                    mm_start;
    logic [OPERAND_BITS-1:0] mm_a;
    logic [OPERAND_BITS-1:0] mm_b;
    logic                    mm_done;
    logic [OPERAND_BITS-1:0] mm_product;

    logic                    out_free;
    logic                    exp_upper_zero;

    assign out_free       = !m_tvalid_reg || m_tready;
    assign exp_upper_zero = (exp_reg[OPERAND_BITS-1:1] == '0);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= OPERAND_BITS'(65537);
            modulus_reg  <= ONE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_wdata;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (exponent_reg == '0 || modulus_reg == '0) begin
                        state_next = mexp_pkg::ST_DONE;
                    end else begin
                        state_next = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE: begin
                if (mm_done) begin
                    state_next = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_BIT: begin
                if (exp_reg == '0) begin
                    state_next = mexp_pkg::ST_DONE;
                end else if (exp_reg[0]) begin
                    state_next = mexp_pkg::ST_MUL;
                end else begin
                    state_next = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL: begin
                if (mm_done) begin
                    state_next = exp_upper_zero ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_SQR: begin
                if (mm_done) begin
                    state_next = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        mm_start      = 1'b0;
        mm_a          = sq_reg;
        mm_b          = sq_reg;
        exp_next      = exp_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    exp_next = exponent_reg;
                    if (exponent_reg == '0) begin
                        acc_next = ONE;
                    end else if (modulus_reg == '0) begin
                        acc_next = '0;
                    end else begin
                        // message mod modulus as message * 1
                        mm_start = 1'b1;
                        mm_a     = s_tdata[OPERAND_BITS-1:0];
                        mm_b     = ONE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE: begin
                if (mm_done) begin
                    sq_next  = mm_product;
                    acc_next = (modulus_reg == ONE) ? '0 : ONE;
                end
            end
            mexp_pkg::ST_BIT: begin
                if (exp_reg != '0) begin
                    mm_start = 1'b1;
                    if (exp_reg[0]) begin
                        mm_a = acc_reg;
                    end
                end
            end
            mexp_pkg::ST_MUL: begin
                if (mm_done) begin
                    acc_next = mm_product;
                    // no square needed after the top exponent bit
                    if (!exp_upper_zero) begin
                        mm_start = 1'b1;
                    end
                end
            end
            mexp_pkg::ST_SQR: begin
                if (mm_done) begin
                    sq_next  = mm_product;
                    exp_next = exp_reg >> 1;
                end
            end
            mexp_pkg::ST_DONE: begin
                if (out_free) begin
                    m_data_next   = acc_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mexp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

endmodule
